// ===== rtl/core/prc_pkg.sv =====
package prc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int RANGE_WIDTH     = 23;
  localparam int QUOT_WIDTH      = RANGE_WIDTH + 1;
  localparam int REG_INDEX_WIDTH = 1;

  localparam logic [RANGE_WIDTH-1:0] RANGE_RESET = RANGE_WIDTH'(128000);

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_MAX_RANGE = 1'b0,
    REG_ENABLE    = 1'b1
  } reg_index_t;

endpackage

// ===== rtl/core/prc_in_if.sv =====
interface prc_in_if import prc_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] target_x;
  logic signed [W-1:0] target_y;

  modport source (output valid, point_x, point_y, target_x, target_y, input ready);
  modport sink   (input valid, point_x, point_y, target_x, target_y, output ready);
endinterface

// ===== rtl/core/prc_out_if.sv =====
interface prc_out_if import prc_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] new_x;
  logic signed [W-1:0] new_y;
  logic                clamped;

  modport source (output valid, new_x, new_y, clamped, input ready);
  modport sink   (input valid, new_x, new_y, clamped, output ready);
endinterface

// ===== rtl/core/prc_front.sv =====
module prc_front import prc_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic signed [W-1:0]    px,
  input  logic signed [W-1:0]    py,
  input  logic signed [W-1:0]    tx,
  input  logic signed [W-1:0]    ty,
  input  logic [RANGE_WIDTH-1:0] max_range,
  input  logic                   enable,
  output logic                   o_valid,
  output logic [2*W+1:0]         sum_sq,
  output logic                   pass,
  output logic [W:0]             adx,
  output logic [W:0]             ady,
  output logic [4*W+1:0]         side
);
  localparam int SQW = 2*W + 2;
  localparam int RRW = 2*RANGE_WIDTH;
  localparam int CW  = SQW > RRW ? SQW : RRW;

  logic                v1, v2, v3, v4;
  logic [4*W-1:0]      c1, c2, c3, c4;
  logic signed [W:0]   dx1, dy1;
  logic                sx2, sy2, sx3, sy3, sx4, sy4;
  logic [W:0]          ax2, ay2, ax3, ay3, ax4, ay4;
  logic [SQW-1:0]      qx3, qy3, sum4;
  logic [RRW-1:0]      rr3;
  logic                pass4;
  logic [SQW-1:0]      sum_next;
  logic [CW-1:0]       sum_e, rr_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign sum_next = qx3 + qy3;
  assign sum_e    = CW'(sum_next);
  assign rr_e     = CW'(rr3);

  always_ff @(posedge clk) begin
    if (adv) begin
      c1    <= {px, py, tx, ty};
      dx1   <= (W+1)'(tx) - (W+1)'(px);
      dy1   <= (W+1)'(ty) - (W+1)'(py);
      c2    <= c1;
      sx2   <= dx1[W];
      sy2   <= dy1[W];
      ax2   <= dx1[W] ? (W+1)'(-dx1) : (W+1)'(dx1);
      ay2   <= dy1[W] ? (W+1)'(-dy1) : (W+1)'(dy1);
      c3    <= c2;
      sx3   <= sx2;
      sy3   <= sy2;
      ax3   <= ax2;
      ay3   <= ay2;
      qx3   <= SQW'(ax2 * ax2);
      qy3   <= SQW'(ay2 * ay2);
      rr3   <= RRW'(max_range * max_range);
      c4    <= c3;
      sx4   <= sx3;
      sy4   <= sy3;
      ax4   <= ax3;
      ay4   <= ay3;
      sum4  <= sum_next;
      pass4 <= !enable || (sum_e < rr_e);
    end
  end

  assign o_valid = v4;
  assign sum_sq  = sum4;
  assign pass    = pass4;
  assign adx     = ax4;
  assign ady     = ay4;
  assign side    = {c4, sx4, sy4};
endmodule

// ===== rtl/core/prc_sqrt.sv =====
module prc_sqrt import prc_pkg::*; #(
  parameter int W      = COORD_WIDTH_DEF,
  parameter int SIDE_W = 6*COORD_WIDTH_DEF + 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2*W+1:0]    s,
  input  logic [SIDE_W-1:0] side_in,
  output logic              o_valid,
  output logic [W:0]        root,
  output logic [SIDE_W-1:0] side_out
);
  localparam int DW  = W + 1;
  localparam int SQW = 2*W + 2;

  logic              v   [DW];
  logic [DW-1:0]     r   [DW];
  logic [SQW-1:0]    rem [DW];
  logic [SIDE_W-1:0] sd  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    localparam int B = DW - 1 - i;
    logic              v_p;
    logic [DW-1:0]     r_p;
    logic [SQW-1:0]    rem_p;
    logic [SIDE_W-1:0] sd_p;
    logic [SQW-1:0]    trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_p   = in_valid;
      assign r_p   = '0;
      assign rem_p = s;
      assign sd_p  = side_in;
    end else begin : g_rest
      assign v_p   = v[i-1];
      assign r_p   = r[i-1];
      assign rem_p = rem[i-1];
      assign sd_p  = sd[i-1];
    end

    assign trial = (SQW'(r_p) << (B + 1)) + (SQW'(1) << (2*B));
    assign ge    = rem_p >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv) begin
        v[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[i]  <= sd_p;
        rem[i] <= ge ? rem_p - trial : rem_p;
        r[i]   <= ge ? (r_p | (DW'(1) << B)) : r_p;
      end
    end
  end

  assign o_valid  = v[DW-1];
  assign root     = r[DW-1];
  assign side_out = sd[DW-1];
endmodule

// ===== rtl/core/prc_div.sv =====
module prc_div import prc_pkg::*; #(
  parameter int W      = COORD_WIDTH_DEF,
  parameter int SIDE_W = 4*COORD_WIDTH_DEF + 3
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [W:0]             root,
  input  logic [W:0]             adx,
  input  logic [W:0]             ady,
  input  logic [RANGE_WIDTH-1:0] max_range,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   o_valid,
  output logic [QUOT_WIDTH-1:0]  qx,
  output logic [QUOT_WIDTH-1:0]  qy,
  output logic                   zero,
  output logic [SIDE_W-1:0]      side_out
);
  localparam int DW  = W + 1;
  localparam int QW  = QUOT_WIDTH;
  localparam int NW  = DW + QW;

  logic              vm, zm;
  logic [NW-1:0]     nxm, nym;
  logic [DW-1:0]     dm;
  logic [SIDE_W-1:0] sdm;

  logic              v   [QW];
  logic              z   [QW];
  logic [NW-1:0]     rx  [QW];
  logic [NW-1:0]     ry  [QW];
  logic [QW-1:0]     ox  [QW];
  logic [QW-1:0]     oy  [QW];
  logic [DW-1:0]     d   [QW];
  logic [SIDE_W-1:0] sd  [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxm <= NW'(max_range * adx) + NW'(root >> 1);
      nym <= NW'(max_range * ady) + NW'(root >> 1);
      dm  <= root;
      zm  <= root == '0;
      sdm <= side_in;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic              v_p, z_p;
    logic [NW-1:0]     rx_p, ry_p, sub;
    logic [QW-1:0]     ox_p, oy_p;
    logic [DW-1:0]     d_p;
    logic [SIDE_W-1:0] sd_p;
    logic              gx, gy;

    if (i == 0) begin : g_first
      assign v_p  = vm;
      assign z_p  = zm;
      assign rx_p = nxm;
      assign ry_p = nym;
      assign ox_p = '0;
      assign oy_p = '0;
      assign d_p  = dm;
      assign sd_p = sdm;
    end else begin : g_rest
      assign v_p  = v[i-1];
      assign z_p  = z[i-1];
      assign rx_p = rx[i-1];
      assign ry_p = ry[i-1];
      assign ox_p = ox[i-1];
      assign oy_p = oy[i-1];
      assign d_p  = d[i-1];
      assign sd_p = sd[i-1];
    end

    assign sub = NW'(d_p) << K;
    assign gx  = rx_p >= sub;
    assign gy  = ry_p >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (adv) begin
        v[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        z[i]  <= z_p;
        d[i]  <= d_p;
        sd[i] <= sd_p;
        rx[i] <= gx ? rx_p - sub : rx_p;
        ry[i] <= gy ? ry_p - sub : ry_p;
        ox[i] <= gx ? (ox_p | (QW'(1) << K)) : ox_p;
        oy[i] <= gy ? (oy_p | (QW'(1) << K)) : oy_p;
      end
    end
  end

  assign o_valid  = v[QW-1];
  assign qx       = ox[QW-1];
  assign qy       = oy[QW-1];
  assign zero     = z[QW-1];
  assign side_out = sd[QW-1];
endmodule

// ===== rtl/core/point_range_constrainer.sv =====
// Point range constrainer: keeps a mesh point within max_range of its target when constrain_enable is set.
// in_ch carries one point and its target per transaction (signed Q16.8);
// out_ch returns the new point and a clamped flag, one result per input.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 max_range, 1 constrain_enable); write only while the pipeline is empty.
// Throughput: one transaction per cycle, sustained while out_ch accepts results.
// Pipeline: the squared-distance front end (4 stages), the bit-per-stage square
// root (COORD_WIDTH+1 stages), the range multiply and bit-per-stage divider
// (QUOT_WIDTH+1 stages) and the output register.
// Reset clears every valid bit and loads max_range = 128000 and
// constrain_enable = 0. When out_ch.ready is low and a result is waiting,
// the whole pipeline holds and in_ch.ready drops; nothing is lost or repeated.
module point_range_constrainer import prc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [REG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [RANGE_WIDTH-1:0]     cfg_data,
  prc_in_if.sink                     in_ch,
  prc_out_if.source                  out_ch
);
  localparam int W   = COORD_WIDTH;
  localparam int FSW = 4*W + 2;
  localparam int SSW = FSW + 1 + 2*(W + 1);
  localparam int DSW = FSW + 1;
  localparam int QW  = QUOT_WIDTH;
  localparam int VW  = (W > QW ? W : QW) + 2;
  localparam logic signed [VW-1:0] HI = VW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  logic [RANGE_WIDTH-1:0] max_range;
  logic                   constrain_enable;
  logic                   adv;

  logic                   f_valid, f_pass;
  logic [2*W+1:0]         f_sum;
  logic [W:0]             f_adx, f_ady;
  logic [FSW-1:0]         f_side;

  logic                   s_valid;
  logic [W:0]             s_root;
  logic [SSW-1:0]         s_side;
  logic [FSW-1:0]         s_fside;
  logic                   s_pass;
  logic [W:0]             s_adx, s_ady;

  logic                   d_valid, d_zero;
  logic [QW-1:0]          d_qx, d_qy;
  logic [DSW-1:0]         d_side;

  logic signed [W-1:0]    o_px, o_py, o_tx, o_ty;
  logic                   o_sx, o_sy, o_pass;
  logic signed [VW-1:0]   vx, vy;
  logic signed [W-1:0]    nx_next, ny_next;

  logic                   ov, oclamped;
  logic signed [W-1:0]    onx, ony;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range        <= RANGE_RESET;
      constrain_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAX_RANGE: max_range        <= cfg_data;
        REG_ENABLE:    constrain_enable <= cfg_data[0];
      endcase
    end
  end

  assign adv         = !ov || out_ch.ready;
  assign in_ch.ready = adv;

  prc_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .px        (in_ch.point_x),
    .py        (in_ch.point_y),
    .tx        (in_ch.target_x),
    .ty        (in_ch.target_y),
    .max_range (max_range),
    .enable    (constrain_enable),
    .o_valid   (f_valid),
    .sum_sq    (f_sum),
    .pass      (f_pass),
    .adx       (f_adx),
    .ady       (f_ady),
    .side      (f_side)
  );

  prc_sqrt #(.W(W), .SIDE_W(SSW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (f_valid),
    .s        (f_sum),
    .side_in  ({f_side, f_pass, f_adx, f_ady}),
    .o_valid  (s_valid),
    .root     (s_root),
    .side_out (s_side)
  );

  assign {s_fside, s_pass, s_adx, s_ady} = s_side;

  prc_div #(.W(W), .SIDE_W(DSW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_valid),
    .root      (s_root),
    .adx       (s_adx),
    .ady       (s_ady),
    .max_range (max_range),
    .side_in   ({s_fside, s_pass}),
    .o_valid   (d_valid),
    .qx        (d_qx),
    .qy        (d_qy),
    .zero      (d_zero),
    .side_out  (d_side)
  );

  assign {o_px, o_py, o_tx, o_ty, o_sx, o_sy, o_pass} = d_side;

  always_comb begin
    vx = o_sx ? VW'(o_tx) + VW'(signed'({1'b0, d_qx}))
              : VW'(o_tx) - VW'(signed'({1'b0, d_qx}));
    vy = o_sy ? VW'(o_ty) + VW'(signed'({1'b0, d_qy}))
              : VW'(o_ty) - VW'(signed'({1'b0, d_qy}));
    if (vx > HI) vx = HI;
    if (vx < LO) vx = LO;
    if (vy > HI) vy = HI;
    if (vy < LO) vy = LO;
    if (o_pass) begin
      nx_next = o_px;
      ny_next = o_py;
    end else if (d_zero) begin
      nx_next = o_tx;
      ny_next = o_ty;
    end else begin
      nx_next = vx[W-1:0];
      ny_next = vy[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      onx      <= nx_next;
      ony      <= ny_next;
      oclamped <= !o_pass;
    end
  end

  assign out_ch.valid   = ov;
  assign out_ch.new_x   = onx;
  assign out_ch.new_y   = ony;
  assign out_ch.clamped = oclamped;
endmodule
